@@ hdl/dir_pkg.sv @@
// Shared types, constants and helper functions for the duration increment rounder.
package dir_pkg;

   localparam int MagWidth   = 84;
   localparam int StepWidth  = 63;
   localparam int LowWidth   = 64;
   localparam int HighWidth  = 20;
   localparam int ModeWidth  = 4;
   localparam int DivStages  = 28;
   localparam int BitsPerDiv = MagWidth / DivStages;

   localparam logic [MagWidth-1:0] MaxDur = {20'h77359, 64'h3FFFFFFFFFFFFFFF};

   typedef enum logic [ModeWidth-1:0] {
      MODE_CEIL        = 4'd0,
      MODE_FLOOR       = 4'd1,
      MODE_EXPAND      = 4'd2,
      MODE_TRUNC       = 4'd3,
      MODE_HALF_CEIL   = 4'd4,
      MODE_HALF_FLOOR  = 4'd5,
      MODE_HALF_EXPAND = 4'd6,
      MODE_HALF_TRUNC  = 4'd7,
      MODE_HALF_EVEN   = 4'd8
   } round_mode_type;

   typedef enum logic [2:0] {
      UM_ZERO, UM_INF, UM_HALF_ZERO, UM_HALF_INF, UM_HALF_EVEN
   } umode_type;

   // Payload carried down the divider stages.
   typedef struct packed {
      logic                 neg;
      umode_type            umode;
      logic [StepWidth-1:0] step;
      logic [MagWidth-1:0]  mag;
      logic [StepWidth-1:0] rem;
      logic                 qbit;
   } div_data_type;

   typedef struct packed {
      logic [LowWidth-1:0]  result_low;
      logic [HighWidth-1:0] result_high;
      logic                 range_error;
   } rsp_data_type;

   typedef struct packed {
      logic [LowWidth-1:0]        value_low;
      logic signed [HighWidth-1:0] value_high;
      logic [StepWidth-1:0]       step_size;
      logic [ModeWidth-1:0]       round_mode;
   } req_data_type;

   function automatic umode_type map_mode(input logic [ModeWidth-1:0] mode, input logic neg);
      umode_type um;
      begin
         case (mode)
            MODE_CEIL:        um = neg ? UM_ZERO : UM_INF;
            MODE_FLOOR:       um = neg ? UM_INF : UM_ZERO;
            MODE_EXPAND:      um = UM_INF;
            MODE_HALF_CEIL:   um = neg ? UM_HALF_ZERO : UM_HALF_INF;
            MODE_HALF_FLOOR:  um = neg ? UM_HALF_INF : UM_HALF_ZERO;
            MODE_HALF_EXPAND: um = UM_HALF_INF;
            MODE_HALF_TRUNC:  um = UM_HALF_ZERO;
            MODE_HALF_EVEN:   um = UM_HALF_EVEN;
            default:          um = UM_ZERO;
         endcase
         return um;
      end
   endfunction

endpackage

@@ hdl/dir_req_if.sv @@
// Valid/ready channel interface for request beats.
interface dir_req_if;
   logic                 valid;
   logic                 ready;
   dir_pkg::req_data_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/dir_rsp_if.sv @@
// Valid/ready channel interface for result beats.
interface dir_rsp_if;
   logic                 valid;
   logic                 ready;
   dir_pkg::rsp_data_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/dir_div_stage.sv @@
// One restoring-division stage: retires a fixed group of quotient bits per cycle while advance is high.
module dir_div_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  dir_pkg::div_data_type in_data,
   input  logic [6:0]            bit_base,
   output logic                  out_valid,
   output dir_pkg::div_data_type out_data
);
   logic                  valid_ff;
   dir_pkg::div_data_type data_ff;
   dir_pkg::div_data_type data_in;

   always_comb begin
      logic [dir_pkg::StepWidth:0] wide;
      data_in = in_data;
      for (int k = 0; k < dir_pkg::BitsPerDiv; k++) begin
         wide = {data_in.rem, in_data.mag[bit_base - 7'(k)]};
         if (wide >= {1'b0, in_data.step}) begin
            wide = wide - {1'b0, in_data.step};
            data_in.qbit = 1'b1;
         end else begin
            data_in.qbit = 1'b0;
         end
         data_in.rem = wide[dir_pkg::StepWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

@@ hdl/duration_increment_rounder_top.sv @@
// Top level of the duration increment rounder.
// Accepts one duration beat per cycle and returns one result beat per item through
// its pipeline: one input stage, twenty-eight long-division stages of
// three quotient bits each, a rounding stage and a range-check stage. The whole pipeline
// advances together and holds while the result beat waits, so throughput is one
// item per cycle whenever the result side takes beats.
module duration_increment_rounder_top (
   input logic        clock,
   input logic        reset,
   dir_req_if.sink    req,
   dir_rsp_if.source  rsp
);
   localparam int N = dir_pkg::DivStages;

   logic advance;
   logic                  v_ff [0:N];
   dir_pkg::div_data_type d_ff [0:N];
   dir_pkg::div_data_type d_in;

   logic                        rnd_valid_ff;
   logic                        rnd_neg_ff;
   logic [dir_pkg::MagWidth-1:0] rnd_mag_ff;
   logic [dir_pkg::MagWidth-1:0] rnd_mag_in;

   logic                  out_valid_ff;
   dir_pkg::rsp_data_type out_data_ff;
   dir_pkg::rsp_data_type out_data_in;

   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   always_comb begin
      logic neg;
      logic [dir_pkg::MagWidth-1:0] raw;
      raw  = {req.data.value_high, req.data.value_low};
      neg  = raw[dir_pkg::MagWidth-1];
      d_in.neg   = neg;
      d_in.mag   = neg ? (~raw + 1'b1) : raw;
      d_in.step  = (req.data.step_size == '0) ? dir_pkg::StepWidth'(1) : req.data.step_size;
      d_in.umode = dir_pkg::map_mode(req.data.round_mode, neg);
      d_in.rem   = '0;
      d_in.qbit  = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= req.valid;
      end
      if (advance) begin
         d_ff[0] <= d_in;
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_div
      dir_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (v_ff[g]),
         .in_data   (d_ff[g]),
         .bit_base  (7'(dir_pkg::MagWidth - 1 - g * dir_pkg::BitsPerDiv)),
         .out_valid (v_ff[g+1]),
         .out_data  (d_ff[g+1])
      );
   end

   // Rounding: magnitude minus remainder, plus one step if the mode bumps.
   always_comb begin
      dir_pkg::div_data_type q;
      logic bump;
      logic [dir_pkg::StepWidth:0] twice;
      q     = d_ff[N];
      twice = {q.rem, 1'b0};
      bump  = 1'b0;
      if (q.rem != '0) begin
         case (q.umode)
            dir_pkg::UM_INF:  bump = 1'b1;
            dir_pkg::UM_ZERO: bump = 1'b0;
            default: begin
               if (twice > {1'b0, q.step}) begin
                  bump = 1'b1;
               end else if (twice == {1'b0, q.step}) begin
                  bump = (q.umode == dir_pkg::UM_HALF_INF) ||
                         (q.umode == dir_pkg::UM_HALF_EVEN && q.qbit);
               end
            end
         endcase
      end
      rnd_mag_in = q.mag - dir_pkg::MagWidth'(q.rem)
                   + (bump ? dir_pkg::MagWidth'(q.step) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
      end else if (advance) begin
         rnd_valid_ff <= v_ff[N];
      end
      if (advance) begin
         rnd_mag_ff <= rnd_mag_in;
         rnd_neg_ff <= d_ff[N].neg;
      end
   end

   always_comb begin
      logic [dir_pkg::MagWidth-1:0] s;
      s = rnd_neg_ff ? (~rnd_mag_ff + 1'b1) : rnd_mag_ff;
      if (rnd_mag_ff > dir_pkg::MaxDur) begin
         out_data_in = '{result_low: '0, result_high: '0, range_error: 1'b1};
      end else begin
         out_data_in.result_low  = s[dir_pkg::LowWidth-1:0];
         out_data_in.result_high = s[dir_pkg::MagWidth-1:dir_pkg::LowWidth];
         out_data_in.range_error = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= rnd_valid_ff;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_data_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result beat changed while stalled");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.range_error |-> rsp.data.result_low == '0 &&
      rsp.data.result_high == '0)
      else $error("range error with nonzero result");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      v_ff[N] |-> d_ff[N].rem < d_ff[N].step)
      else $error("remainder not below step");
endmodule
